FILE: design/lptti_pkg.sv
`timescale 1ns / 1ps

package lptti_pkg;

    localparam int COORD_BITS   = 48;
    localparam int MAX_TILE_DIM = 4096;

    localparam int LAT_W      = COORD_BITS + 1;
    localparam int PITCH_W    = COORD_BITS - 1;
    localparam int TILE_W     = 13;
    localparam int LAYER_W    = 16;
    localparam int LOCAL_W    = 24;
    localparam int PROD_W     = 2 * TILE_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COORD_BITS;
    localparam int DIV_STAGES = LAT_W;
    // Latency from the input transfer to the result strobe.
    localparam int LATENCY    = 2 * DIV_STAGES + 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X  = 3'd0,
        CFG_ORIGIN_Y  = 3'd1,
        CFG_PITCH     = 3'd2,
        CFG_TILE_COLS = 3'd3,
        CFG_TILE_ROWS = 3'd4
    } t_cfg_idx;

    // Items that ride alongside the divider stages.
    typedef struct packed {
        logic                    on;
        logic                    neg_x;
        logic                    neg_y;
        logic [LAYER_W-1:0]      layer;
        logic signed [LAT_W-1:0] lat_x;
        logic signed [LAT_W-1:0] lat_y;
    } t_side;

    // Tile size as used: zero reads as one, large values saturate.
    function automatic logic [TILE_W-1:0] tile_size(input logic [TILE_W-1:0] reg_val);
        logic [TILE_W-1:0] res;
        if (reg_val == '0) begin
            res = TILE_W'(1);
        end else if ({19'd0, reg_val} > 32'(MAX_TILE_DIM)) begin
            res = TILE_W'(MAX_TILE_DIM);
        end else begin
            res = reg_val;
        end
        return res;
    endfunction

endpackage

FILE: design/lattice_point_to_tile_index.sv
`timescale 1ns / 1ps

// Channel   Direction  Ports                                   Transfer
// command   in         start, i_point_x/y, i_layer_id          start && !busy
// config    in         i_cfg_we, i_cfg_idx, i_cfg_data         i_cfg_we
// result    out        o_done, o_on_lattice ... o_local_node   o_done
//
// One point enters every clock; busy is always low. Each point passes
// through one offset stage, a 49-stage divider by the lattice pitch, one
// sign stage, a 49-stage divider by the tile size, a floor-correction
// stage, a multiply stage and the output register. Reset is synchronous;
// it clears the valid bits and the origin and sets the pitch and tile
// sizes to one. The receiver cannot stall, so the pipeline never holds.
module lattice_point_to_tile_index (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [lptti_pkg::COORD_BITS-1:0] i_point_x,
    input  logic signed [lptti_pkg::COORD_BITS-1:0] i_point_y,
    input  logic [lptti_pkg::LAYER_W-1:0]        i_layer_id,
    input  logic                                 i_cfg_we,
    input  logic [lptti_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lptti_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                 o_done,
    output logic                                 o_on_lattice,
    output logic signed [lptti_pkg::LAT_W-1:0]   o_node_x,
    output logic signed [lptti_pkg::LAT_W-1:0]   o_node_y,
    output logic [lptti_pkg::LAYER_W-1:0]        o_tile_layer,
    output logic signed [lptti_pkg::LAT_W-1:0]   o_tile_x,
    output logic signed [lptti_pkg::LAT_W-1:0]   o_tile_y,
    output logic [lptti_pkg::LOCAL_W-1:0]        o_local_node
);

    localparam int CB = lptti_pkg::COORD_BITS;
    localparam int LW = lptti_pkg::LAT_W;
    localparam int PW = lptti_pkg::PITCH_W;
    localparam int TW = lptti_pkg::TILE_W;

    // Configuration registers, read directly by every stage. The user must
    // change them only while the pipeline is empty; nothing here enforces it.
    logic signed [CB-1:0] r_origin_x, r_origin_y;
    logic [PW-1:0]        r_pitch;
    logic [TW-1:0]        r_tile_cols, r_tile_rows;
    logic [TW-1:0]        cols, rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x  <= '0;
            r_origin_y  <= '0;
            r_pitch     <= PW'(1);
            r_tile_cols <= TW'(1);
            r_tile_rows <= TW'(1);
        end else if (i_cfg_we) begin
            case (lptti_pkg::t_cfg_idx'(i_cfg_idx))
                lptti_pkg::CFG_ORIGIN_X:  r_origin_x  <= i_cfg_data;
                lptti_pkg::CFG_ORIGIN_Y:  r_origin_y  <= i_cfg_data;
                lptti_pkg::CFG_PITCH:     r_pitch     <= i_cfg_data[PW-1:0];
                lptti_pkg::CFG_TILE_COLS: r_tile_cols <= i_cfg_data[TW-1:0];
                lptti_pkg::CFG_TILE_ROWS: r_tile_rows <= i_cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end

    assign cols = lptti_pkg::tile_size(r_tile_cols);
    assign rows = lptti_pkg::tile_size(r_tile_rows);
    assign busy = 1'b0;

    // Offset stage: subtract the origin at one extra bit.
    logic                 r_a_val;
    logic signed [LW-1:0] r_a_dx, r_a_dy;
    logic [lptti_pkg::LAYER_W-1:0] r_a_layer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_val <= 1'b0;
        end else begin
            r_a_val <= start && !busy;
        end
        r_a_dx    <= LW'(i_point_x) - LW'(r_origin_x);
        r_a_dy    <= LW'(i_point_y) - LW'(r_origin_y);
        r_a_layer <= i_layer_id;
    end

    lptti_pkg::t_side d1_side_in, d1_side_out;
    logic             d1_val;
    logic [LW-1:0]    d1_qx, d1_qy;
    logic [PW-1:0]    d1_rx, d1_ry;

    always_comb begin
        d1_side_in       = '0;
        d1_side_in.neg_x = r_a_dx[LW-1];
        d1_side_in.neg_y = r_a_dy[LW-1];
        d1_side_in.layer = r_a_layer;
    end

    lptti_div u_div_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_a_val),
        .i_num_x (r_a_dx[LW-1] ? LW'(-r_a_dx) : LW'(r_a_dx)),
        .i_num_y (r_a_dy[LW-1] ? LW'(-r_a_dy) : LW'(r_a_dy)),
        .i_den_x (r_pitch),
        .i_den_y (r_pitch),
        .i_side  (d1_side_in),
        .o_valid (d1_val),
        .o_quo_x (d1_qx),
        .o_quo_y (d1_qy),
        .o_rem_x (d1_rx),
        .o_rem_y (d1_ry),
        .o_side  (d1_side_out)
    );

    // Sign stage: exact quotients become the lattice indices.
    logic                 r_b_val;
    lptti_pkg::t_side     r_b_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_val <= 1'b0;
        end else begin
            r_b_val <= d1_val;
        end
        r_b_side.on    <= (r_pitch != '0) && (d1_rx == '0) && (d1_ry == '0);
        r_b_side.layer <= d1_side_out.layer;
        r_b_side.neg_x <= d1_side_out.neg_x;
        r_b_side.neg_y <= d1_side_out.neg_y;
        r_b_side.lat_x <= d1_side_out.neg_x ? LW'(-d1_qx) : LW'(d1_qx);
        r_b_side.lat_y <= d1_side_out.neg_y ? LW'(-d1_qy) : LW'(d1_qy);
    end

    lptti_pkg::t_side d2_side_out;
    logic             d2_val;
    logic [LW-1:0]    d2_qx, d2_qy;
    logic [PW-1:0]    d2_rx, d2_ry;

    lptti_div u_div_tile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_b_val),
        .i_num_x (r_b_side.lat_x[LW-1] ? LW'(-r_b_side.lat_x) : LW'(r_b_side.lat_x)),
        .i_num_y (r_b_side.lat_y[LW-1] ? LW'(-r_b_side.lat_y) : LW'(r_b_side.lat_y)),
        .i_den_x (PW'(cols)),
        .i_den_y (PW'(rows)),
        .i_side  (r_b_side),
        .o_valid (d2_val),
        .o_quo_x (d2_qx),
        .o_quo_y (d2_qy),
        .o_rem_x (d2_rx),
        .o_rem_y (d2_ry),
        .o_side  (d2_side_out)
    );

    // Floor stage: a negative index with a remainder rounds down one more
    // tile and its remainder is taken from the far edge of the tile.
    logic                 r_c_val;
    lptti_pkg::t_side     r_c_side;
    logic signed [LW-1:0] r_c_tx, r_c_ty;
    logic [TW-1:0]        r_c_rx, r_c_ry;
    logic                 nx, ny;

    assign nx = d2_side_out.lat_x[LW-1];
    assign ny = d2_side_out.lat_y[LW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_val <= 1'b0;
        end else begin
            r_c_val <= d2_val;
        end
        r_c_side <= d2_side_out;
        if (nx && (d2_rx != '0)) begin
            r_c_tx <= ~LW'(d2_qx);
            r_c_rx <= cols - TW'(d2_rx);
        end else begin
            r_c_tx <= nx ? LW'(-d2_qx) : LW'(d2_qx);
            r_c_rx <= TW'(d2_rx);
        end
        if (ny && (d2_ry != '0)) begin
            r_c_ty <= ~LW'(d2_qy);
            r_c_ry <= rows - TW'(d2_ry);
        end else begin
            r_c_ty <= ny ? LW'(-d2_qy) : LW'(d2_qy);
            r_c_ry <= TW'(d2_ry);
        end
    end

    // Multiply stage: local row times tile width.
    logic                 r_d_val;
    lptti_pkg::t_side     r_d_side;
    logic signed [LW-1:0] r_d_tx, r_d_ty;
    logic [TW-1:0]        r_d_rx;
    logic [lptti_pkg::PROD_W-1:0] r_d_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_val <= 1'b0;
        end else begin
            r_d_val <= r_c_val;
        end
        r_d_side <= r_c_side;
        r_d_tx   <= r_c_tx;
        r_d_ty   <= r_c_ty;
        r_d_rx   <= r_c_rx;
        r_d_prod <= r_c_ry * cols;
    end

    // Output register: an off-lattice point gives all zero fields.
    logic [lptti_pkg::PROD_W-1:0] n_local;
    assign n_local = r_d_prod + lptti_pkg::PROD_W'(r_d_rx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_d_val;
        end
        o_on_lattice <= r_d_side.on;
        o_node_x     <= r_d_side.on ? r_d_side.lat_x : '0;
        o_node_y     <= r_d_side.on ? r_d_side.lat_y : '0;
        o_tile_layer <= r_d_side.on ? r_d_side.layer : '0;
        o_tile_x     <= r_d_side.on ? r_d_tx : '0;
        o_tile_y     <= r_d_side.on ? r_d_ty : '0;
        o_local_node <= r_d_side.on ? n_local[lptti_pkg::LOCAL_W-1:0] : '0;
    end

    // Every result strobe traces back to a command transfer at fixed latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, lptti_pkg::LATENCY))
        else $error("result strobe without matching command");

    // An off-lattice result carries zero indices.
    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_on_lattice) |->
            (o_node_x == '0 && o_node_y == '0 && o_local_node == '0))
        else $error("off-lattice result has nonzero fields");

    // The local remainder never reaches the tile width.
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_val |-> (r_d_rx < cols))
        else $error("local column out of tile");

endmodule

FILE: design/lptti_div.sv
`timescale 1ns / 1ps

// Pair of unsigned restoring dividers, one quotient bit per register stage.
module lptti_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic [lptti_pkg::LAT_W-1:0]      i_num_x,
    input  logic [lptti_pkg::LAT_W-1:0]      i_num_y,
    input  logic [lptti_pkg::PITCH_W-1:0]    i_den_x,
    input  logic [lptti_pkg::PITCH_W-1:0]    i_den_y,
    input  lptti_pkg::t_side                 i_side,
    output logic                             o_valid,
    output logic [lptti_pkg::LAT_W-1:0]      o_quo_x,
    output logic [lptti_pkg::LAT_W-1:0]      o_quo_y,
    output logic [lptti_pkg::PITCH_W-1:0]    o_rem_x,
    output logic [lptti_pkg::PITCH_W-1:0]    o_rem_y,
    output lptti_pkg::t_side                 o_side
);

    localparam int NS = lptti_pkg::DIV_STAGES;
    localparam int QW = lptti_pkg::LAT_W;
    localparam int RW = lptti_pkg::PITCH_W;

    logic             r_val  [0:NS];
    logic [QW-1:0]    r_nq_x [0:NS];
    logic [QW-1:0]    r_nq_y [0:NS];
    logic [RW-1:0]    r_rem_x[0:NS];
    logic [RW-1:0]    r_rem_y[0:NS];
    lptti_pkg::t_side r_side [0:NS];

    assign r_val[0]   = i_valid;
    assign r_nq_x[0]  = i_num_x;
    assign r_nq_y[0]  = i_num_y;
    assign r_rem_x[0] = '0;
    assign r_rem_y[0] = '0;
    assign r_side[0]  = i_side;

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic [RW:0]   n_try_x, n_try_y;
        logic          n_bit_x, n_bit_y;
        logic [RW-1:0] n_rem_x, n_rem_y;

        always_comb begin
            n_try_x = {r_rem_x[k], r_nq_x[k][QW-1]};
            n_try_y = {r_rem_y[k], r_nq_y[k][QW-1]};
            n_bit_x = (n_try_x >= {1'b0, i_den_x});
            n_bit_y = (n_try_y >= {1'b0, i_den_y});
            n_rem_x = n_bit_x ? RW'(n_try_x - {1'b0, i_den_x}) : RW'(n_try_x);
            n_rem_y = n_bit_y ? RW'(n_try_y - {1'b0, i_den_y}) : RW'(n_try_y);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val[k+1] <= 1'b0;
            end else begin
                r_val[k+1] <= r_val[k];
            end
            r_nq_x[k+1]  <= {r_nq_x[k][QW-2:0], n_bit_x};
            r_nq_y[k+1]  <= {r_nq_y[k][QW-2:0], n_bit_y};
            r_rem_x[k+1] <= n_rem_x;
            r_rem_y[k+1] <= n_rem_y;
            r_side[k+1]  <= r_side[k];
        end
    end

    assign o_valid = r_val[NS];
    assign o_quo_x = r_nq_x[NS];
    assign o_quo_y = r_nq_y[NS];
    assign o_rem_x = r_rem_x[NS];
    assign o_rem_y = r_rem_y[NS];
    assign o_side  = r_side[NS];

endmodule

FILE: tb/tb_lattice_point_to_tile_index.sv
`timescale 1ns / 1ps

module tb_lattice_point_to_tile_index;

    localparam int LIMIT_NS = 2_000_000;

    // One expected result of the tile lookup, at the widths of the result ports.
    typedef struct {
        logic                               on;
        logic signed [lptti_pkg::LAT_W-1:0] lat_x;
        logic signed [lptti_pkg::LAT_W-1:0] lat_y;
        logic [lptti_pkg::LAYER_W-1:0]      layer;
        logic signed [lptti_pkg::LAT_W-1:0] tile_x;
        logic signed [lptti_pkg::LAT_W-1:0] tile_y;
        logic [lptti_pkg::LOCAL_W-1:0]      local_node;
    } t_tile_hit;

    // Keeps its own copy of the lattice and tile setup, predicts the result of
    // each accepted point, and checks the results in order of arrival.
    class t_tile_board;
        t_tile_hit       hits_due[$];
        int              errors;
        logic [47:0]     org_x, org_y;
        logic [46:0]     pitch;
        logic [12:0]     cols_reg, rows_reg;

        function new();
            errors   = 0;
            org_x    = '0;
            org_y    = '0;
            pitch    = 47'd1;
            cols_reg = 13'd1;
            rows_reg = 13'd1;
        endfunction

        function void set_reg(lptti_pkg::t_cfg_idx idx,
                              logic [lptti_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                lptti_pkg::CFG_ORIGIN_X:  org_x    = data;
                lptti_pkg::CFG_ORIGIN_Y:  org_y    = data;
                lptti_pkg::CFG_PITCH:     pitch    = data[46:0];
                lptti_pkg::CFG_TILE_COLS: cols_reg = data[12:0];
                lptti_pkg::CFG_TILE_ROWS: rows_reg = data[12:0];
                default: ;
            endcase
        endfunction

        // A tile size of zero counts as one; anything past the maximum saturates.
        function longint span(logic [12:0] r);
            longint s;
            s = longint'(r);
            if (s == 0) s = 1;
            if (s > lptti_pkg::MAX_TILE_DIM) s = lptti_pkg::MAX_TILE_DIM;
            return s;
        endfunction

        function void note_point(logic [47:0] px, logic [47:0] py, logic [15:0] layer);
            t_tile_hit e;
            longint    dx, dy, p, cw, ch, lx, ly, tx, ty, rx, ry;
            dx = longint'($signed(px)) - longint'($signed(org_x));
            dy = longint'($signed(py)) - longint'($signed(org_y));
            p  = longint'(pitch);
            cw = span(cols_reg);
            ch = span(rows_reg);
            e  = '{default: '0};
            if (p != 0 && (dx % p) == 0 && (dy % p) == 0) begin
                lx = dx / p;
                ly = dy / p;
                // Floor division: pull a negative remainder back into the tile.
                tx = lx / cw;
                rx = lx % cw;
                if (rx < 0) begin
                    tx -= 1;
                    rx += cw;
                end
                ty = ly / ch;
                ry = ly % ch;
                if (ry < 0) begin
                    ty -= 1;
                    ry += ch;
                end
                e.on         = 1'b1;
                e.lat_x      = lx[lptti_pkg::LAT_W-1:0];
                e.lat_y      = ly[lptti_pkg::LAT_W-1:0];
                e.layer      = layer;
                e.tile_x     = tx[lptti_pkg::LAT_W-1:0];
                e.tile_y     = ty[lptti_pkg::LAT_W-1:0];
                e.local_node = lptti_pkg::LOCAL_W'(ry * cw + rx);
            end
            hits_due.insert(hits_due.size(), e);
        endfunction

        function void report(string what, longint got, longint want);
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
            errors++;
        endfunction

        function void check_result(t_tile_hit r);
            t_tile_hit e;
            if (hits_due.size() == 0) begin
                report("unexpected result", 1, 0);
                return;
            end
            e = hits_due.pop_front();
            if (r.on !== e.on)                 report("on_lattice", r.on, e.on);
            if (r.lat_x !== e.lat_x)           report("node_x", r.lat_x, e.lat_x);
            if (r.lat_y !== e.lat_y)           report("node_y", r.lat_y, e.lat_y);
            if (r.layer !== e.layer)           report("tile_layer", r.layer, e.layer);
            if (r.tile_x !== e.tile_x)         report("tile_x", r.tile_x, e.tile_x);
            if (r.tile_y !== e.tile_y)         report("tile_y", r.tile_y, e.tile_y);
            if (r.local_node !== e.local_node) report("local_node", r.local_node, e.local_node);
        endfunction
    endclass

    logic                                    i_clk;
    logic                                    i_rst_n;
    logic                                    start;
    logic                                    busy;
    logic signed [lptti_pkg::COORD_BITS-1:0] i_point_x;
    logic signed [lptti_pkg::COORD_BITS-1:0] i_point_y;
    logic [lptti_pkg::LAYER_W-1:0]           i_layer_id;
    logic                                    i_cfg_we;
    logic [lptti_pkg::CFG_IDX_W-1:0]         i_cfg_idx;
    logic [lptti_pkg::CFG_DATA_W-1:0]        i_cfg_data;
    logic                                    o_done;
    logic                                    o_on_lattice;
    logic signed [lptti_pkg::LAT_W-1:0]      o_node_x;
    logic signed [lptti_pkg::LAT_W-1:0]      o_node_y;
    logic [lptti_pkg::LAYER_W-1:0]           o_tile_layer;
    logic signed [lptti_pkg::LAT_W-1:0]      o_tile_x;
    logic signed [lptti_pkg::LAT_W-1:0]      o_tile_y;
    logic [lptti_pkg::LOCAL_W-1:0]           o_local_node;

    t_tile_board board = new();
    bit          gaps_on;

    lattice_point_to_tile_index i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_layer_id   (i_layer_id),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_done       (o_done),
        .o_on_lattice (o_on_lattice),
        .o_node_x     (o_node_x),
        .o_node_y     (o_node_y),
        .o_tile_layer (o_tile_layer),
        .o_tile_x     (o_tile_x),
        .o_tile_y     (o_tile_y),
        .o_local_node (o_local_node)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Both sides are sampled at the rising edge, before the nonblocking updates
    // of that edge land, so a command transfer and a result are seen exactly as
    // they stood during the cycle that the edge closes.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                board.note_point(i_point_x, i_point_y, i_layer_id);
            end
            if (o_done) begin
                board.check_result('{o_on_lattice, o_node_x, o_node_y, o_tile_layer,
                                     o_tile_x, o_tile_y, o_local_node});
            end
        end
    end

    // Start stays high from one transfer into the next unless an idle cycle is
    // drawn, so back-to-back transfers never lower and raise it in one step.
    task automatic send_point(logic [47:0] px, logic [47:0] py, logic [15:0] layer);
        while (gaps_on && $urandom_range(99) < 22) begin
            start <= 1'b0;
            i_point_x <= 48'({$urandom, $urandom});
            @(posedge i_clk);
        end
        start      <= 1'b1;
        i_point_x  <= px;
        i_point_y  <= py;
        i_layer_id <= layer;
        do @(posedge i_clk); while (busy);
    endtask

    // Writes all five registers in consecutive cycles; the enable is lowered
    // only after the last one so it never sees two assignments in one step.
    task automatic load_setup(logic [47:0] ox, logic [47:0] oy, logic [46:0] p,
                              logic [12:0] cw, logic [12:0] ch);
        lptti_pkg::t_cfg_idx                idx;
        logic [lptti_pkg::CFG_DATA_W-1:0]   vals [5];
        vals = '{ox, oy, {1'b0, p}, {35'd0, cw}, {35'd0, ch}};
        for (int k = 0; k < 5; k++) begin
            idx = lptti_pkg::t_cfg_idx'(k);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx;
            i_cfg_data <= vals[k];
            @(posedge i_clk);
            board.set_reg(idx, vals[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Lets the pipeline empty before the setup may change again.
    task automatic drain();
        start <= 1'b0;
        while (board.hits_due.size() != 0) @(posedge i_clk);
        repeat (lptti_pkg::LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    // Most points are lattice nodes near the origin so that the tile and local
    // fields carry real content; the rest are arbitrary coordinates.
    task automatic send_random_point();
        longint kx, ky;
        if ($urandom_range(99) < 70) begin
            if ($urandom_range(9) == 0) begin
                kx = longint'($signed($urandom));
                ky = longint'($signed($urandom));
            end else begin
                kx = longint'($urandom_range(40000)) - 20000;
                ky = longint'($urandom_range(40000)) - 20000;
            end
            send_point(48'(longint'($signed(board.org_x)) + kx * longint'(board.pitch)),
                       48'(longint'($signed(board.org_y)) + ky * longint'(board.pitch)),
                       16'($urandom));
        end else begin
            send_point(rand48(), rand48(), 16'($urandom));
        end
    endtask

    initial begin
        logic [46:0] p;
        logic [47:0] pmax;
        pmax       = 48'h7FFF_FFFF_FFFF;
        start      = 1'b0;
        i_point_x  = '0;
        i_point_y  = '0;
        i_layer_id = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        gaps_on    = 1'b1;
        i_rst_n    = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed points under the reset setup: every point is a node.
        send_point(48'd0, 48'd0, 16'd0);
        send_point(pmax, 48'h8000_0000_0000, 16'hFFFF);
        send_point(48'h8000_0000_0000, pmax, 16'h1234);
        send_point(48'hFFFF_FFFF_FFFF, 48'd1, 16'h8001);
        drain();

        // Odd pitch, zero row count, off-lattice points and negative floors.
        load_setup(48'd10, 48'hFFFF_FFFF_FFF6, 47'd3, 13'd5, 13'd0);
        send_point(48'd10, 48'hFFFF_FFFF_FFF6, 16'hA5A5);
        send_point(48'd7, 48'hFFFF_FFFF_FFF3, 16'h5A5A);
        send_point(48'd11, 48'd0, 16'd1);
        send_point(48'd13, 48'hFFFF_FFFF_FFF7, 16'd2);
        send_point(48'd22, 48'd2, 16'd3);
        send_point(pmax, 48'h8000_0000_0000, 16'hFFFF);
        drain();

        // Origin at the far corner, largest pitch, columns that saturate, rows at the maximum.
        load_setup(48'h8000_0000_0000, pmax, 47'h7FFF_FFFF_FFFF, 13'h1FFF, 13'd4096);
        send_point(48'h8000_0000_0000, pmax, 16'd7);
        send_point(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'd8);
        send_point(pmax, 48'd0, 16'd9);
        send_point(48'd0, 48'd0, 16'd10);
        drain();

        // A pitch of zero puts nothing on the lattice.
        load_setup(pmax, 48'h8000_0000_0000, 47'd0, 13'd4095, 13'd4097);
        send_point(pmax, 48'h8000_0000_0000, 16'hFFFF);
        send_point(48'd0, 48'd0, 16'd0);
        drain();

        // Random phases with random setups; one phase runs with no idle cycles.
        for (int ph = 0; ph < 7; ph++) begin
            if ($urandom_range(3) == 0) p = 47'({$urandom, $urandom});
            else p = 47'($urandom_range(1000, 1));
            load_setup(ph[0] ? rand48() : 48'($urandom_range(2000)) - 48'd1000,
                       ph[1] ? rand48() : 48'($urandom_range(2000)) - 48'd1000,
                       p,
                       13'($urandom_range(ph == 3 ? 8191 : 70)),
                       13'($urandom_range(ph == 5 ? 8191 : 70)));
            gaps_on = (ph != 2);
            for (int n = 0; n < 55; n++) send_random_point();
            drain();
        end
        gaps_on = 1'b1;

        if (board.errors == 0 && board.hits_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
design/lptti_pkg.sv
design/lptti_div.sv
design/lattice_point_to_tile_index.sv
tb/tb_lattice_point_to_tile_index.sv
